>>> sv/pss_pkg.sv
package pss_pkg;

  localparam int MAX_PERIOD   = 4096;
  localparam int PTR_W        = $clog2(MAX_PERIOD);
  localparam int PERIOD_W     = $clog2(MAX_PERIOD + 1);
  localparam int IN_PERIOD_W  = 13;
  localparam int SAMPLE_W     = 16;
  localparam int SUM_W        = SAMPLE_W + 1;
  localparam int PROD_W       = SAMPLE_W + SUM_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SAMPLE_W-1:0] LFSR_TAPS     = 16'hB400;
  localparam logic [SAMPLE_W-1:0] DAMP_RESET    = 16'd32768;
  localparam logic [SAMPLE_W-1:0] SEED_RESET    = 16'd44257;

  localparam logic [CFG_IDX_W-1:0] REG_DAMP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD,
    S_MUL,
    S_WR,
    S_HOLD
  } pss_state_t;

  typedef struct packed {
    logic accept;
    logic fill;
    logic rd_cur;
    logic mul;
    logic wr;
    logic ld_out;
  } pss_cmd_t;

  typedef struct packed {
    logic pluck;
    logic fill_last;
    logic out_free;
  } pss_status_t;

endpackage

>>> sv/pss_in_if.sv
interface pss_in_if;
  import pss_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   trigger_level;
  logic [IN_PERIOD_W-1:0] period_length;

  modport source (output valid, output trigger_level, output period_length, input ready);
  modport sink   (input valid, input trigger_level, input period_length, output ready);
endinterface

>>> sv/pss_out_if.sv
interface pss_out_if;
  import pss_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> sv/pss_cfg_if.sv
interface pss_cfg_if;
  import pss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/pss_ctrl.sv
module pss_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pss_pkg::pss_status_t status,
  output pss_pkg::pss_cmd_t    cmd
);
  import pss_pkg::*;

  pss_state_t state_r;
  pss_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = status.pluck ? S_FILL : S_RD;
        end
      end
      S_FILL: begin
        if (status.fill_last) begin
          state_nxt = S_RD;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_WR;
      S_WR: begin
        state_nxt = status.out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.fill   = (state_r == S_FILL);
    cmd.rd_cur = (state_r == S_RD);
    cmd.mul    = (state_r == S_MUL);
    cmd.wr     = (state_r == S_WR);
    cmd.ld_out = ((state_r == S_WR) || (state_r == S_HOLD)) && status.out_free;
  end

  a_pluck_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && status.pluck) |=> (state_r == S_FILL))
    else $error("pluck did not start the refill");

  a_tick_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !status.pluck) |=> (state_r == S_RD))
    else $error("tick did not go to the read step");

  a_wr_follows_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_WR))
    else $error("write step did not follow the multiply");

endmodule

>>> sv/pss_datapath.sv
module pss_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pss_pkg::pss_cmd_t                cmd,
  output pss_pkg::pss_status_t             status,
  input  logic                             in_trigger_level,
  input  logic [pss_pkg::IN_PERIOD_W-1:0]  in_period_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pss_pkg::SAMPLE_W-1:0]     out_sample,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pss_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_PERIOD];

  logic [SAMPLE_W-1:0] damp_r;
  logic [SAMPLE_W-1:0] lfsr_r;
  logic                last_trig_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PTR_W-1:0]    ptr_r;
  logic [PTR_W-1:0]    fill_cnt_r;
  logic [SAMPLE_W-1:0] nb_r;
  logic [SAMPLE_W-1:0] rdata_r;
  logic                rd_zero_r;
  logic                entry0_valid_r;
  logic [PROD_W-1:0]   prod_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;

  logic [SAMPLE_W-1:0] lfsr_nxt;
  logic [PERIOD_W-1:0] period_clamped;
  logic [PTR_W-1:0]    ptr_prev;
  logic [PTR_W-1:0]    ptr_inc;
  logic [PTR_W-1:0]    raddr;
  logic                re;
  logic [PTR_W-1:0]    waddr;
  logic [SAMPLE_W-1:0] wdata;
  logic                we;
  logic [SAMPLE_W-1:0] rd_eff;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] sat_sample;
  logic                out_free;

  // galois lfsr, right shift
  always_comb begin
    lfsr_nxt = lfsr_r >> 1;
    if (lfsr_r[0]) begin
      lfsr_nxt = lfsr_nxt ^ LFSR_TAPS;
    end
  end

  always_comb begin
    if (in_period_length == '0) begin
      period_clamped = PERIOD_W'(1);
    end else if (32'(in_period_length) > 32'(MAX_PERIOD)) begin
      period_clamped = PERIOD_W'(MAX_PERIOD);
    end else begin
      period_clamped = PERIOD_W'(in_period_length);
    end
  end

  assign ptr_prev = (ptr_r == '0) ? PTR_W'(period_r - PERIOD_W'(1)) : ptr_r - PTR_W'(1);
  assign ptr_inc  = ((PERIOD_W'(ptr_r) + PERIOD_W'(1)) == period_r) ? '0 : ptr_r + PTR_W'(1);
  assign raddr    = cmd.mul ? ptr_prev : ptr_r;
  assign re       = cmd.rd_cur || cmd.mul;

  assign rd_eff     = rd_zero_r ? '0 : rdata_r;
  assign sum        = {1'b0, rd_eff} + {1'b0, nb_r};
  assign sat_sample = prod_r[PROD_W-1] ? '1 : prod_r[PROD_W-2:SAMPLE_W];

  assign we    = cmd.fill || cmd.wr;
  assign waddr = cmd.fill ? fill_cnt_r : ptr_r;
  assign wdata = cmd.fill ? lfsr_nxt : sat_sample;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    status.pluck     = in_trigger_level && !last_trig_r;
    status.fill_last = (PERIOD_W'(fill_cnt_r) + PERIOD_W'(1)) == period_r;
    status.out_free  = out_free;
  end

  // delay line
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry0_valid_r <= 1'b0;
      rd_zero_r      <= 1'b1;
    end else begin
      if (re) begin
        rd_zero_r <= (raddr == '0) && !entry0_valid_r;
      end
      if (we && (waddr == '0)) begin
        entry0_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damp_r      <= DAMP_RESET;
      lfsr_r      <= SEED_RESET;
      last_trig_r <= 1'b0;
      period_r    <= PERIOD_W'(1);
      ptr_r       <= '0;
      fill_cnt_r  <= '0;
      nb_r        <= '0;
    end else begin
      if (cfg_valid && (cfg_index == REG_DAMP_GAIN)) begin
        damp_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_NOISE_SEED)) begin
        lfsr_r <= cfg_data;
      end else if (cmd.fill) begin
        lfsr_r <= lfsr_nxt;
      end
      if (cmd.accept) begin
        last_trig_r <= in_trigger_level;
        if (status.pluck) begin
          period_r   <= period_clamped;
          ptr_r      <= '0;
          fill_cnt_r <= '0;
        end
      end
      if (cmd.fill) begin
        fill_cnt_r <= fill_cnt_r + PTR_W'(1);
      end
      if (cmd.wr) begin
        nb_r  <= (period_r == PERIOD_W'(1)) ? sat_sample : rd_eff;
        ptr_r <= ptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(damp_r) * PROD_W'(sum);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_sample_r <= sat_sample;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign cfg_ready  = 1'b1;

  a_ptr_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    PERIOD_W'(ptr_r) < period_r)
    else $error("pointer outside the active period");

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    (period_r != '0) && (32'(period_r) <= 32'(MAX_PERIOD)))
    else $error("active period out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_pluck_resets_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && status.pluck) |=> (ptr_r == '0) && (fill_cnt_r == '0))
    else $error("pluck did not rewind the pointer");

endmodule

>>> sv/plucked_string_synth.sv
// plucked string voice, one audio tick per input transaction
// in_ch: trigger_level and period_length; a 0 to 1 change of trigger_level
//   plucks, refilling the delay line with period_length noise samples
//   (0 taken as 1, above 4096 taken as 4096) and rewinding the pointer
// out_ch: one sample_out per tick, unsigned q0.16
// cfg_ch: index 0 damp_gain, index 1 noise_seed (also reloads the lfsr);
//   other indexes ignored; always ready, write only while idle
// timing: a tick without pluck goes through the memory read, multiply and
//   write back steps to the output register, and the next transaction is
//   taken once the block is back in idle; a pluck first refills the delay
//   line one sample at a time through the single delay line write port
// a new transaction is accepted only after the previous result has been
//   placed in the output register; a stalled receiver holds the block in
//   its final step until the register frees up
// reset: damp_gain 0.5, seed 44257, period 1, entry zero of the delay line
//   reads as zero until written; no clearing pass
module plucked_string_synth (
  input  logic      clk,
  input  logic      rst_n,
  pss_in_if.sink    in_ch,
  pss_out_if.source out_ch,
  pss_cfg_if.sink   cfg_ch
);
  import pss_pkg::*;

  pss_cmd_t    cmd;
  pss_status_t status;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pss_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_trigger_level (in_ch.trigger_level),
    .in_period_length (in_ch.period_length),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_sample       (out_ch.sample_out),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data)
  );

endmodule

>>> dv/plucked_string_synth_tb.sv
`timescale 1ns / 1ps

module plucked_string_synth_tb;
  import pss_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int MAX_IDLE       = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 235;
  localparam int DIRECTED_ROWS  = 26;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef enum logic {
    ROW_TICK,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  trig;
    logic [CFG_DATA_W-1:0] value;
    logic [CFG_IDX_W-1:0]  idx;
    logic                  known;
    logic [SAMPLE_W-1:0]   known_sample;
  } stim_row_t;

  logic clk;
  logic rst_n;

  pss_in_if  in_if ();
  pss_out_if out_if ();
  pss_cfg_if cfg_if ();

  plucked_string_synth u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // string model state
  logic [SAMPLE_W-1:0] string_mem [MAX_PERIOD];
  logic [PTR_W-1:0]    model_ptr;
  logic [PERIOD_W-1:0] model_period;
  logic [SAMPLE_W-1:0] model_neighbour;
  logic [SAMPLE_W-1:0] model_lfsr;
  logic [SAMPLE_W-1:0] model_damp;
  logic                model_last_trig;

  logic [SAMPLE_W-1:0] expected_samples [$];
  logic [SAMPLE_W-1:0] predicted_sample;
  int                  error_count;
  int                  idle_cycles;
  bit                  calm;
  bit                  hold_req;
  logic                trig_now;
  logic                item_known;
  logic [SAMPLE_W-1:0] item_known_sample;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b1, 16'd0},
    '{ROW_TICK, 1'b0, 16'd8191,   '0,             1'b1, 16'd0},
    '{ROW_TICK, 1'b1, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b1, 16'd5,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd3,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b1, 16'd3,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b1, 16'd8191,   '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b1, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_CFG,  1'b0, 16'hFFFF,   REG_DAMP_GAIN,  1'b0, 16'd0},
    '{ROW_TICK, 1'b1, 16'd4096,   '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_CFG,  1'b0, 16'd0,      REG_NOISE_SEED, 1'b0, 16'd0},
    '{ROW_TICK, 1'b1, 16'd2,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b0, 16'd0},
    '{ROW_CFG,  1'b0, 16'h1234,   REG_UNUSED_2,   1'b0, 16'd0},
    '{ROW_CFG,  1'b0, 16'hFFFF,   REG_UNUSED_3,   1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd1,      '0,             1'b0, 16'd0},
    '{ROW_CFG,  1'b0, DAMP_RESET, REG_DAMP_GAIN,  1'b0, 16'd0},
    '{ROW_CFG,  1'b0, SEED_RESET, REG_NOISE_SEED, 1'b0, 16'd0},
    '{ROW_TICK, 1'b1, 16'd1,      '0,             1'b0, 16'd0},
    '{ROW_TICK, 1'b0, 16'd0,      '0,             1'b0, 16'd0}
  };

  function automatic logic [SAMPLE_W-1:0] next_string_sample(
    input logic                   trig,
    input logic [IN_PERIOD_W-1:0] len
  );
    logic [PTR_W-1:0]    ptr;
    logic [PTR_W-1:0]    prev;
    logic [SUM_W-1:0]    sum;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] s;
    if (trig && !model_last_trig) begin
      if (len == '0) begin
        model_period = PERIOD_W'(1);
      end else if (len > MAX_PERIOD) begin
        model_period = PERIOD_W'(MAX_PERIOD);
      end else begin
        model_period = PERIOD_W'(len);
      end
      model_ptr = '0;
      // galois noise refill, advance then store
      for (int i = 0; i < model_period; i++) begin
        if (model_lfsr[0]) begin
          model_lfsr = (model_lfsr >> 1) ^ LFSR_TAPS;
        end else begin
          model_lfsr = model_lfsr >> 1;
        end
        string_mem[i] = model_lfsr;
      end
    end
    model_last_trig = trig;

    ptr = model_ptr;
    if (PERIOD_W'(ptr) >= model_period) ptr = '0;
    sum  = SUM_W'(string_mem[ptr]) + SUM_W'(model_neighbour);
    prod = PROD_W'(model_damp) * PROD_W'(sum);
    s    = prod[PROD_W-1] ? '1 : prod[SAMPLE_W +: SAMPLE_W];
    string_mem[ptr] = s;

    prev = (ptr == '0) ? PTR_W'(model_period - 1'b1) : ptr - 1'b1;
    model_neighbour = string_mem[prev];
    if (PERIOD_W'(ptr) + 1'b1 >= model_period) begin
      model_ptr = '0;
    end else begin
      model_ptr = ptr + 1'b1;
    end
    return s;
  endfunction

  task automatic report_mismatch(
    input string               what,
    input logic [SAMPLE_W-1:0] got,
    input logic [SAMPLE_W-1:0] want
  );
    $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // model update and result check on every transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        predicted_sample = next_string_sample(in_if.trigger_level, in_if.period_length);
        if (item_known) begin
          expected_samples.push_back(item_known_sample);
        end else begin
          expected_samples.push_back(predicted_sample);
        end
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_DAMP_GAIN: begin
            model_damp = cfg_if.data;
          end
          REG_NOISE_SEED: begin
            model_lfsr = cfg_if.data;
          end
          default: begin
          end
        endcase
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample_out with no tick pending", out_if.sample_out, '0);
        end else begin
          if (out_if.sample_out !== expected_samples[0]) begin
            report_mismatch("sample_out", out_if.sample_out, expected_samples[0]);
          end
          void'(expected_samples.pop_front());
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  initial begin
    do @(posedge clk); while (idle_cycles < WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random back-pressure, one long hold-off on request
  initial begin
    int gap;
    out_if.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  task automatic send_tick(
    input logic                   trig,
    input logic [IN_PERIOD_W-1:0] len,
    input logic                   known,
    input logic [SAMPLE_W-1:0]    known_sample
  );
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.trigger_level <= trig;
    in_if.period_length <= len;
    item_known          <= known;
    item_known_sample   <= known_sample;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(
    input logic [CFG_IDX_W-1:0]  idx,
    input logic [CFG_DATA_W-1:0] val
  );
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(
    input logic [CFG_DATA_W-1:0] damp,
    input logic [CFG_DATA_W-1:0] seed,
    input logic [CFG_IDX_W-1:0]  spare_idx
  );
    logic                   trig;
    logic [IN_PERIOD_W-1:0] len;
    int                     r;
    quiesce();
    write_reg(REG_DAMP_GAIN, damp);
    write_reg(REG_NOISE_SEED, seed);
    write_reg(spare_idx, CFG_DATA_W'($urandom));
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      calm = (i >= 2 * PHASE_ITEMS / 3) && (i < 5 * PHASE_ITEMS / 6);
      if (i == PHASE_ITEMS / 3) hold_req = 1'b1;
      if (i == PHASE_ITEMS / 2) quiesce();
      r    = $urandom_range(0, 99);
      trig = trig_now;
      len  = IN_PERIOD_W'($urandom_range(0, 8191));
      if (!trig_now && r < 12) begin
        // pluck, mostly short strings
        trig = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 70) begin
          len = IN_PERIOD_W'($urandom_range(1, 16));
        end else if (r < 88) begin
          len = IN_PERIOD_W'($urandom_range(17, 255));
        end else if (r < 95) begin
          len = IN_PERIOD_W'($urandom_range(256, 1023));
        end else if (r < 97) begin
          len = '0;
        end else begin
          len = IN_PERIOD_W'($urandom_range(4000, 8191));
        end
      end else if (trig_now && r < 30) begin
        trig = 1'b0;
      end
      trig_now = trig;
      send_tick(trig, len, 1'b0, '0);
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.trigger_level = 1'b0;
    in_if.period_length = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    item_known          = 1'b0;
    item_known_sample   = '0;
    calm                = 1'b0;
    hold_req            = 1'b0;
    trig_now            = 1'b0;
    error_count         = 0;
    idle_cycles         = 0;
    for (int i = 0; i < MAX_PERIOD; i++) string_mem[i] = '0;
    model_ptr       = '0;
    model_period    = PERIOD_W'(1);
    model_neighbour = '0;
    model_damp      = DAMP_RESET;
    model_lfsr      = SEED_RESET;
    model_last_trig = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        quiesce();
        write_reg(directed_rows[k].idx, directed_rows[k].value);
      end else begin
        trig_now = directed_rows[k].trig;
        send_tick(directed_rows[k].trig, directed_rows[k].value[IN_PERIOD_W-1:0],
                  directed_rows[k].known, directed_rows[k].known_sample);
      end
    end

    run_phase(16'd655, 16'd1, REG_UNUSED_2);
    run_phase(DAMP_RESET, 16'hFFFF, REG_UNUSED_3);
    run_phase(16'hFFFF, SEED_RESET, REG_UNUSED_2);
    run_phase(DAMP_RESET, 16'd0, REG_UNUSED_3);
    run_phase(16'd0, CFG_DATA_W'($urandom_range(1, 65535)), REG_UNUSED_2);
    run_phase(CFG_DATA_W'($urandom_range(655, 32768)), CFG_DATA_W'($urandom), REG_UNUSED_3);
    run_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), REG_UNUSED_2);
    run_phase(DAMP_RESET, SEED_RESET, REG_UNUSED_3);

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pss_pkg.sv
sv/pss_in_if.sv
sv/pss_out_if.sv
sv/pss_cfg_if.sv
sv/pss_ctrl.sv
sv/pss_datapath.sv
sv/plucked_string_synth.sv
dv/plucked_string_synth_tb.sv
